[rtl/npc_pkg.sv]
// ----------------------------------------------------------------------------
// npc_pkg
// Types, codes and constants shared by the nearest palette color block.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int IDX_W             = 8;
  localparam int END_W             = 9;
  localparam int COMP_W            = 8;
  localparam int SQ_W              = 16;
  localparam int DIST_W            = 18;

  // Start value of the running best distance, above any real distance.
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(257 * 257 + 257 * 257 + 257 * 257);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    CFG_FIRST_INDEX = 2'd0,
    CFG_END_INDEX   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    mode_e              mode;
    logic [IDX_W-1:0]   entry_index;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] best_index;
  } out_rsp_t;

  typedef struct packed {
    cfg_reg_e         index;
    logic [END_W-1:0] wdata;
  } cfg_req_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;   // write the request color into the palette
    logic             start;  // latch query color, reset best to index
    logic             issue;  // read one palette entry, tagged with index
    logic [IDX_W-1:0] index;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             busy;      // entries still in the compare pipeline
    logic             zero_hit;  // exact match found
    logic [IDX_W-1:0] best_index;
  } dp_status_t;

endpackage

[rtl/npc_stream_if.sv]
// ----------------------------------------------------------------------------
// npc_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface npc_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[rtl/npc_dp.sv]
// ----------------------------------------------------------------------------
// npc_dp
// Palette memory and distance pipeline: read, square, sum and compare.
// ----------------------------------------------------------------------------
module npc_dp #(
  parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  npc_pkg::dp_cmd_t             cmd_i,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr_i,
  input  npc_pkg::in_req_t             req_data_i,
  output npc_pkg::dp_status_t          status_o
);
  import npc_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = ($clog2(PALETTE_DEPTH + 1) > END_W) ? $clog2(PALETTE_DEPTH + 1) : END_W;

  logic [3*COMP_W-1:0] mem [PALETTE_DEPTH];

  logic [CW-1:0]       wr_ext;
  logic [AW-1:0]       wr_addr;

  logic [COMP_W-1:0]   qr_q, qg_q, qb_q;
  logic                v1_q;
  logic [IDX_W-1:0]    tag1_q;
  logic [3*COMP_W-1:0] rdata_q;

  logic                v2_q;
  logic [IDX_W-1:0]    tag2_q;
  logic [SQ_W-1:0]     sqr_q, sqg_q, sqb_q;

  logic [DIST_W-1:0]   best_dist_q;
  logic [IDX_W-1:0]    best_q;
  logic                zero_q;

  logic [COMP_W-1:0]   dr, dg, db;
  logic [DIST_W-1:0]   cand_dist;

  function automatic logic [COMP_W-1:0] abs_diff(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign wr_ext  = CW'(req_data_i.entry_index);
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[wr_addr] <= {req_data_i.red, req_data_i.green, req_data_i.blue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign dr = abs_diff(qr_q, rdata_q[3*COMP_W-1:2*COMP_W]);
  assign dg = abs_diff(qg_q, rdata_q[2*COMP_W-1:COMP_W]);
  assign db = abs_diff(qb_q, rdata_q[COMP_W-1:0]);

  assign cand_dist = DIST_W'(sqr_q) + DIST_W'(sqg_q) + DIST_W'(sqb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        zero_q <= 1'b0;
      end else if (v2_q && !zero_q && cand_dist < best_dist_q && cand_dist == '0) begin
        zero_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qr_q        <= req_data_i.red;
      qg_q        <= req_data_i.green;
      qb_q        <= req_data_i.blue;
      best_q      <= cmd_i.index;
      best_dist_q <= DIST_START;
    end else if (v2_q && !zero_q && cand_dist < best_dist_q) begin
      best_q      <= tag2_q;
      best_dist_q <= cand_dist;
    end
    tag1_q <= cmd_i.index;
    tag2_q <= tag1_q;
    sqr_q  <= SQ_W'(dr) * SQ_W'(dr);
    sqg_q  <= SQ_W'(dg) * SQ_W'(dg);
    sqb_q  <= SQ_W'(db) * SQ_W'(db);
  end

  assign status_o.busy       = v1_q | v2_q;
  assign status_o.zero_hit   = zero_q;
  assign status_o.best_index = best_q;

endmodule

[rtl/npc_ctrl.sv]
// ----------------------------------------------------------------------------
// npc_ctrl
// Request handshake, configuration registers, scan sequencer, result register.
// ----------------------------------------------------------------------------
module npc_ctrl #(
  parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  npc_pkg::in_req_t                 req_data_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output npc_pkg::out_rsp_t                rsp_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  npc_pkg::cfg_req_t                cfg_data_i,
  output npc_pkg::dp_cmd_t                 cmd_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr_o,
  input  npc_pkg::dp_status_t              status_i
);
  import npc_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = ($clog2(PALETTE_DEPTH + 1) > END_W) ? $clog2(PALETTE_DEPTH + 1) : END_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    stop_q, stop_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [END_W-1:0] end_q, end_d;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_q, out_d;

  logic             req_fire;
  logic [CW-1:0]    end_ext, first_ext, stop_calc, cnt_inc;

  assign req_ready_o = (state_q == ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;
  assign rd_addr_o   = cnt_q[AW-1:0];

  assign end_ext   = CW'(end_q);
  assign first_ext = CW'(first_q);
  assign stop_calc = (end_ext > DEPTH_C) ? DEPTH_C : end_ext;
  assign cnt_inc   = cnt_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    stop_d      = stop_q;
    first_d     = first_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_d       = out_q;
    cmd_o       = '0;

    if (cfg_valid_i) begin
      case (cfg_data_i.index)
        CFG_FIRST_INDEX: first_d = cfg_data_i.wdata[IDX_W-1:0];
        CFG_END_INDEX:   end_d   = cfg_data_i.wdata;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_data_i.mode == MODE_QUERY) begin
            cmd_o.start = 1'b1;
            cmd_o.index = first_q;
            cnt_d       = first_ext;
            stop_d      = stop_calc;
            state_d     = (first_ext >= stop_calc) ? ST_DONE : ST_SCAN;
          end else begin
            cmd_o.load = (CW'(req_data_i.entry_index) < DEPTH_C);
          end
        end
      end
      ST_SCAN: begin
        if (status_i.zero_hit) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
          cmd_o.index = cnt_q[IDX_W-1:0];
          cnt_d       = cnt_inc;
          if (cnt_inc == stop_q) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.best_index = status_i.best_index;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      stop_q      <= '0;
      first_q     <= '0;
      end_q       <= END_W'(256);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stop_q      <= stop_d;
      first_q     <= first_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

[rtl/nearest_palette_color.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color
// Nearest palette color search by squared RGB distance.
// ----------------------------------------------------------------------------
// A load request writes one palette entry, if its index is below the palette
// depth, and gives no result. A query request scans entries first_index
// up to but not including end_index (clipped to the palette depth) and
// returns the index of the first entry at least distance. The scan reads
// one entry per cycle from the palette memory. A query steps through accept,
// the reads, a drain of the read, square and compare stages and a post of
// the result; an exact match stops the reads once it has passed the compare
// stage. An empty range answers first_index without reading the palette.
// The result sits in an output register, so the next request is taken while
// it waits. Entries must be loaded before a query scans them.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
  parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  npc_stream_if.sink   req_i,
  npc_stream_if.source rsp_o,
  npc_stream_if.sink   cfg_i
);
  import npc_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [AW-1:0]   rd_addr;

  npc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .req_data_i (req_i.data),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .rsp_data_o (rsp_o.data),
    .cfg_valid_i(cfg_i.valid),
    .cfg_ready_o(cfg_i.ready),
    .cfg_data_i (cfg_i.data),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .status_i   (status)
  );

  npc_dp #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .req_data_i(req_i.data),
    .status_o  (status)
  );

endmodule

[rtl/npc_checker.sv]
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks of the nearest palette color block.
// ----------------------------------------------------------------------------
module npc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input npc_pkg::mode_e req_mode_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input logic           cfg_ready_i
);
  import npc_pkg::*;

  // A pending result is held until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // A query blocks new requests while it runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_mode_i == MODE_QUERY |=> !req_ready_i)
    else $error("request taken during a query");

  // A load completes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_mode_i == MODE_LOAD |=> req_ready_i)
    else $error("load stalled the request channel");

  // The configuration port takes writes even while a query runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .req_mode_i (req_i.data.mode),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .cfg_ready_i(cfg_i.ready)
);
